/* sv/vpr_pkg.sv */
package vpr_pkg;

  // field and working widths
  localparam int unsigned CoordBits     = 16;
  localparam int unsigned AngleBits     = 16;
  localparam int unsigned Guard         = 16;
  localparam int unsigned WorkBits      = CoordBits + Guard + 3;
  localparam int unsigned AccBits       = 32;
  localparam int unsigned ZBits         = AccBits + 2;
  localparam int unsigned SplitBits     = 32;
  localparam int unsigned HiBits        = WorkBits - SplitBits;
  localparam int unsigned RoundBits     = HiBits + 17;
  localparam int unsigned MaxSteps      = 32;
  localparam int unsigned DefIterations = 16;

  // quarter turn in 32-bit binary angle units and the cordic gain correction
  localparam logic [AccBits-1:0] QuarterTurn = 32'h4000_0000;
  localparam logic [AccBits-1:0] KGain       = 32'h9B74_EDA8;

  typedef struct packed {
    logic signed [CoordBits-1:0] in_x;
    logic signed [CoordBits-1:0] in_y;
    logic signed [AngleBits-1:0] rot_angle;
  } vpr_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic        [CoordBits-1:0] magnitude;
    logic signed [AngleBits-1:0] direction;
    logic                        clipped;
  } vpr_out_t;

  // working set carried down the micro-rotation pipeline
  typedef struct packed {
    logic                       zero;
    logic signed [WorkBits-1:0] vec_u;
    logic signed [WorkBits-1:0] vec_v;
    logic        [AccBits-1:0]  acc;
    logic signed [WorkBits-1:0] rot_u;
    logic signed [WorkBits-1:0] rot_v;
    logic signed [ZBits-1:0]    rot_z;
  } vpr_state_t;

  // atan(2^-idx) as a 32-bit binary angle
  function automatic logic [AccBits-1:0] atan_step(input int unsigned idx);
    logic [AccBits-1:0] val;
    case (idx)
      0:  val = 32'h2000_0000;
      1:  val = 32'h12E4_051D;
      2:  val = 32'h09FB_385B;
      3:  val = 32'h0511_11D4;
      4:  val = 32'h028B_0D43;
      5:  val = 32'h0145_D7E1;
      6:  val = 32'h00A2_F61E;
      7:  val = 32'h0051_7C55;
      8:  val = 32'h0028_BE53;
      9:  val = 32'h0014_5F2F;
      10: val = 32'h000A_2F98;
      11: val = 32'h0005_17CC;
      12: val = 32'h0002_8BE6;
      13: val = 32'h0001_45F3;
      14: val = 32'h0000_A2FA;
      15: val = 32'h0000_517D;
      16: val = 32'h0000_28BE;
      17: val = 32'h0000_145F;
      18: val = 32'h0000_0A30;
      19: val = 32'h0000_0518;
      20: val = 32'h0000_028C;
      21: val = 32'h0000_0146;
      22: val = 32'h0000_00A3;
      23: val = 32'h0000_0051;
      24: val = 32'h0000_0029;
      25: val = 32'h0000_0014;
      26: val = 32'h0000_000A;
      27: val = 32'h0000_0005;
      28: val = 32'h0000_0003;
      29: val = 32'h0000_0001;
      30: val = 32'h0000_0001;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* sv/vpr_micro_rot.sv */
module vpr_micro_rot #(
  parameter int unsigned Step = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vpr_pkg::vpr_state_t data_i,
  output logic               valid_o,
  output vpr_pkg::vpr_state_t data_o
);
  import vpr_pkg::*;

  localparam logic [AccBits-1:0] AtanStep = atan_step(Step);
  localparam logic signed [ZBits-1:0] AtanZ =
    signed'({{(ZBits-AccBits){1'b0}}, AtanStep});

  logic signed [WorkBits-1:0] vu, vv, ru, rv;
  logic signed [WorkBits-1:0] vu_sh, vv_sh, ru_sh, rv_sh;
  vpr_state_t data_d, data_q;
  logic       valid_q;

  assign vu = data_i.vec_u;
  assign vv = data_i.vec_v;
  assign ru = data_i.rot_u;
  assign rv = data_i.rot_v;

  assign vu_sh = vu >>> Step;
  assign vv_sh = vv >>> Step;
  assign ru_sh = ru >>> Step;
  assign rv_sh = rv >>> Step;

  // one micro-rotation for vectoring and for rotation side by side
  always_comb begin
    data_d = data_i;
    if (!vv[WorkBits-1]) begin
      data_d.vec_u = vu + vv_sh;
      data_d.vec_v = vv - vu_sh;
      data_d.acc   = data_i.acc + AtanStep;
    end else begin
      data_d.vec_u = vu - vv_sh;
      data_d.vec_v = vv + vu_sh;
      data_d.acc   = data_i.acc - AtanStep;
    end
    if (!data_i.rot_z[ZBits-1]) begin
      data_d.rot_u = ru - rv_sh;
      data_d.rot_v = rv + ru_sh;
      data_d.rot_z = data_i.rot_z - AtanZ;
    end else begin
      data_d.rot_u = ru + rv_sh;
      data_d.rot_v = rv - ru_sh;
      data_d.rot_z = data_i.rot_z + AtanZ;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/vpr_finish.sv */
module vpr_finish (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  vpr_pkg::vpr_state_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  output vpr_pkg::vpr_out_t   data_o,
  input  logic                stall_i
);
  import vpr_pkg::*;

  localparam int unsigned Lanes   = 3;
  localparam int unsigned LaneMag = 0;
  localparam int unsigned LaneX   = 1;
  localparam int unsigned LaneY   = 2;
  localparam int unsigned SumBits = HiBits + SplitBits + 1;

  localparam logic [RoundBits-1:0] MagMax =
    {{(RoundBits-CoordBits){1'b0}}, {CoordBits{1'b1}}};
  localparam logic [RoundBits-1:0] LimNeg =
    {{(RoundBits-CoordBits){1'b0}}, 1'b1, {(CoordBits-1){1'b0}}};
  localparam logic [RoundBits-1:0] LimPos =
    {{(RoundBits-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}};
  localparam logic [SumBits-1:0] RoundHalf =
    {{(SumBits-Guard){1'b0}}, 1'b1, {(Guard-1){1'b0}}};

  logic ld1, ld2, ld3;
  logic v1_q, v2_q, v3_q;

  // stage 1: absolute values, signs, direction
  logic [Lanes-1:0][WorkBits-1:0] abs_d, abs_q;
  logic [Lanes-1:0]               neg_d, neg_q;
  logic [AccBits-1:0]             dir_acc;
  logic [AngleBits-1:0]           dir_d, dir_q;

  // stage 2: partial products of the gain multiply
  logic [Lanes-1:0][2*SplitBits-1:0]      lo_prod_d, lo_prod_q;
  logic [Lanes-1:0][HiBits+SplitBits-1:0] hi_prod_d, hi_prod_q;
  logic [Lanes-1:0]                       neg2_q;
  logic [AngleBits-1:0]                   dir2_q;

  // stage 3: sum, round, clamp
  logic [Lanes-1:0][SumBits-1:0]   sum;
  logic [Lanes-1:0][RoundBits-1:0] rnd;
  logic [RoundBits-1:0]            mag_c, x_c, y_c;
  logic                            clip_x, clip_y;
  logic [CoordBits-1:0]            x_mag, y_mag;
  vpr_out_t                        out_d, out_q;

  // advance logic, each register fills a bubble or moves on
  assign ld3     = !v3_q || !stall_i;
  assign ld2     = !v2_q || ld3;
  assign ld1     = !v1_q || ld2;
  assign ready_o = ld1;

  always_comb begin
    abs_d[LaneMag] = data_i.vec_u[WorkBits-1] ? '0 : data_i.vec_u;
    neg_d[LaneMag] = 1'b0;
    neg_d[LaneX]   = data_i.rot_v[WorkBits-1];
    abs_d[LaneX]   = neg_d[LaneX] ? WorkBits'(-data_i.rot_v) : data_i.rot_v;
    neg_d[LaneY]   = data_i.rot_u[WorkBits-1];
    abs_d[LaneY]   = neg_d[LaneY] ? WorkBits'(-data_i.rot_u) : data_i.rot_u;
    dir_acc        = data_i.acc + {{(AccBits-AngleBits){1'b0}}, 1'b1, {(AngleBits-1){1'b0}}};
    dir_d          = data_i.zero ? '0 : dir_acc[AccBits-1:AccBits-AngleBits];
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      lo_prod_d[k] = (2*SplitBits)'(abs_q[k][SplitBits-1:0])
                   * (2*SplitBits)'(KGain);
      hi_prod_d[k] = (HiBits+SplitBits)'(abs_q[k][WorkBits-1:SplitBits])
                   * (HiBits+SplitBits)'(KGain);
    end
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      sum[k] = {1'b0, hi_prod_q[k]}
             + {{(SumBits-SplitBits){1'b0}}, lo_prod_q[k][2*SplitBits-1:SplitBits]}
             + RoundHalf;
      rnd[k] = sum[k][SumBits-1:Guard];
    end
    mag_c = (rnd[LaneMag] > MagMax) ? MagMax : rnd[LaneMag];
    if (neg2_q[LaneX]) begin
      clip_x = rnd[LaneX] > LimNeg;
      x_c    = clip_x ? LimNeg : rnd[LaneX];
    end else begin
      clip_x = rnd[LaneX] > LimPos;
      x_c    = clip_x ? LimPos : rnd[LaneX];
    end
    if (neg2_q[LaneY]) begin
      clip_y = rnd[LaneY] > LimNeg;
      y_c    = clip_y ? LimNeg : rnd[LaneY];
    end else begin
      clip_y = rnd[LaneY] > LimPos;
      y_c    = clip_y ? LimPos : rnd[LaneY];
    end
    x_mag           = x_c[CoordBits-1:0];
    y_mag           = y_c[CoordBits-1:0];
    out_d.out_x     = neg2_q[LaneX] ? signed'(CoordBits'(~x_mag + 1'b1)) : signed'(x_mag);
    out_d.out_y     = neg2_q[LaneY] ? signed'(CoordBits'(~y_mag + 1'b1)) : signed'(y_mag);
    out_d.magnitude = mag_c[CoordBits-1:0];
    out_d.direction = signed'(dir2_q);
    out_d.clipped   = clip_x || clip_y;
  end

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      abs_q <= abs_d;
      neg_q <= neg_d;
      dir_q <= dir_d;
    end
    if (ld2) begin
      lo_prod_q <= lo_prod_d;
      hi_prod_q <= hi_prod_d;
      neg2_q    <= neg_q;
      dir2_q    <= dir_q;
    end
    if (ld3) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

/* sv/vector_polar_rotate.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o | in_data_i   (in_x, in_y, rot_angle)
// out     | output    | out_valid_o / out_stall_i | out_data_o (out_x, out_y, magnitude,
//         |           |                        |             direction, clipped)
//
// one item enters per cycle while in_stall_o is low; the stages are one quarter-turn
// prestage, one register per cordic micro-rotation, and three for the gain multiply,
// rounding and clamping. reset clears only the valid bits of the stages.
// a stall on the output holds the last stage; earlier stages keep moving until
// the pipeline is full, and only then is in_stall_o raised.
module vector_polar_rotate #(
  parameter int unsigned ITERATIONS = vpr_pkg::DefIterations
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vpr_pkg::vpr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vpr_pkg::vpr_out_t out_data_o
);
  import vpr_pkg::*;

  localparam logic signed [ZBits-1:0] QuarterZ =
    signed'({{(ZBits-AccBits){1'b0}}, QuarterTurn});

  logic       vld [ITERATIONS+1];
  vpr_state_t st  [ITERATIONS+1];
  logic       ld  [ITERATIONS+2];
  logic       fin_ready;

  logic signed [WorkBits-1:0] xw, yw;
  logic signed [ZBits-1:0]    zw;
  vpr_state_t                 pre_d, pre_q;
  logic                       pre_vld_q;

  // advance chain: a stage loads when empty or when its item moves on
  assign ld[ITERATIONS+1] = fin_ready;
  for (genvar k = 0; k <= ITERATIONS; k++) begin : g_ld
    assign ld[k] = !vld[k] || ld[k+1];
  end
  assign in_stall_o = !ld[0];

  // input scaling and quarter-turn prerotation
  always_comb begin
    xw = signed'({{(WorkBits-CoordBits-Guard){in_data_i.in_x[CoordBits-1]}},
                  in_data_i.in_x, {Guard{1'b0}}});
    yw = signed'({{(WorkBits-CoordBits-Guard){in_data_i.in_y[CoordBits-1]}},
                  in_data_i.in_y, {Guard{1'b0}}});
    zw = signed'({{(ZBits-AccBits){in_data_i.rot_angle[AngleBits-1]}},
                  in_data_i.rot_angle, {(AccBits-AngleBits){1'b0}}});

    pre_d.zero  = (in_data_i.in_x == '0) && (in_data_i.in_y == '0);
    pre_d.vec_u = yw;
    pre_d.vec_v = xw;
    pre_d.acc   = '0;
    if (yw[WorkBits-1]) begin
      if (!xw[WorkBits-1]) begin
        pre_d.vec_u = xw;
        pre_d.vec_v = WorkBits'(-yw);
        pre_d.acc   = QuarterTurn;
      end else begin
        pre_d.vec_u = WorkBits'(-xw);
        pre_d.vec_v = yw;
        pre_d.acc   = AccBits'(-QuarterTurn);
      end
    end

    pre_d.rot_u = yw;
    pre_d.rot_v = xw;
    pre_d.rot_z = zw;
    if (zw > QuarterZ) begin
      pre_d.rot_u = WorkBits'(-xw);
      pre_d.rot_v = yw;
      pre_d.rot_z = zw - QuarterZ;
    end else if (zw < -QuarterZ) begin
      pre_d.rot_u = xw;
      pre_d.rot_v = WorkBits'(-yw);
      pre_d.rot_z = zw + QuarterZ;
    end
  end

  // prestage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (ld[0]) begin
      pre_vld_q <= in_valid_i;
    end
  end

  // prestage data
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      pre_q <= pre_d;
    end
  end

  assign vld[0] = pre_vld_q;
  assign st[0]  = pre_q;

  // one register stage per micro-rotation
  for (genvar k = 1; k <= ITERATIONS; k++) begin : g_step
    vpr_micro_rot #(
      .Step(k - 1)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (ld[k]),
      .valid_i(vld[k-1]),
      .data_i (st[k-1]),
      .valid_o(vld[k]),
      .data_o (st[k])
    );
  end

  // gain correction, rounding and saturation
  vpr_finish u_finish (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld[ITERATIONS]),
    .data_i (st[ITERATIONS]),
    .ready_o(fin_ready),
    .valid_o(out_valid_o),
    .data_o (out_data_o),
    .stall_i(out_stall_i)
  );

endmodule
